/* hw/rtl/dcsm_pkg.sv */
// Shared constants, codes and types for the duty-cycle sensor mux sequencer.
package dcsm_pkg;

  localparam int CountBits = 24;
  localparam int RatioW    = 17;
  localparam int NumW      = RatioW + CountBits;
  localparam int DenW      = CountBits + 1;
  localparam int StepW     = $clog2(RatioW + 1);
  localparam int WordW     = 32;

  localparam logic [RatioW-1:0] RatioScale = RatioW'(100000);

  localparam logic [WordW-1:0] KeepMask    = 32'h3FFF_3FFF;
  localparam logic [WordW-1:0] MuxMask     = 32'hC000_C000;
  localparam logic [WordW-1:0] SelVoltNext = 32'h8000_8000;
  localparam logic [WordW-1:0] SelCurrNext = 32'h0000_8000;
  localparam logic [WordW-1:0] SelStart    = 32'h8000_0000;

  typedef enum logic [1:0] {
    MODE_REG_MUX = 2'd0,
    MODE_GPIO    = 2'd1,
    MODE_BOARD   = 2'd2,
    MODE_FIXED   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    SRC_VOLT = 2'd0,
    SRC_CURR = 2'd1,
    SRC_TEMP = 2'd2,
    SRC_IDLE = 2'd3
  } src_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_START = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_APPLY = 5'b10000
  } state_t;

endpackage

/* hw/rtl/dcsm_if.sv */
// Valid/ready channel interfaces for tick transactions and result transactions.
interface dcsm_in_if;
  logic                          valid;
  logic                          ready;
  logic [dcsm_pkg::CountBits-1:0] low_count;
  logic [dcsm_pkg::CountBits-1:0] high_count;
  logic [dcsm_pkg::WordW-1:0]     switch_reg_now;

  modport source (output valid, low_count, high_count, switch_reg_now, input ready);
  modport sink   (input valid, low_count, high_count, switch_reg_now, output ready);
endinterface

interface dcsm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        long_interval;
  logic                        reg_write_valid;
  logic [dcsm_pkg::WordW-1:0]  reg_write_word;
  logic                        switch_level;
  logic [dcsm_pkg::RatioW-1:0] voltage_primary;
  logic [dcsm_pkg::RatioW-1:0] current_reading;
  logic [dcsm_pkg::RatioW-1:0] temp_filtered;
  logic [dcsm_pkg::RatioW-1:0] temp_aux;

  modport source (output valid, long_interval, reg_write_valid, reg_write_word,
                  switch_level, voltage_primary, current_reading, temp_filtered,
                  temp_aux, input ready);
  modport sink   (input valid, long_interval, reg_write_valid, reg_write_word,
                  switch_level, voltage_primary, current_reading, temp_filtered,
                  temp_aux, output ready);
endinterface

/* hw/rtl/dcsm_div.sv */
// Restoring divider, one quotient bit per cycle; quotient known to fit RatioW bits.
module dcsm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dcsm_pkg::NumW-1:0]     num,
  input  logic [dcsm_pkg::DenW-1:0]     den,
  output logic                          done,
  output logic [dcsm_pkg::RatioW-1:0]   quot
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [dcsm_pkg::StepW-1:0]    cnt_r, cnt_nxt;
  logic [dcsm_pkg::DenW-1:0]     rem_r, rem_nxt;
  logic [dcsm_pkg::RatioW-1:0]   low_r, low_nxt;
  logic [dcsm_pkg::RatioW-1:0]   quot_r, quot_nxt;
  logic [dcsm_pkg::DenW:0]       trial;
  logic                          qbit;

  always_comb begin
    trial    = {rem_r, low_r[dcsm_pkg::RatioW-1]};
    qbit     = (trial >= {1'b0, den});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quot_nxt = quot_r;
    if (start) begin
      // top bits of the numerator are below the divisor
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {1'b0, num[dcsm_pkg::NumW-1 -: dcsm_pkg::CountBits]};
      low_nxt  = num[dcsm_pkg::RatioW-1:0];
    end else if (busy_r) begin
      rem_nxt  = qbit ? dcsm_pkg::DenW'(trial - {1'b0, den})
                      : trial[dcsm_pkg::DenW-1:0];
      low_nxt  = {low_r[dcsm_pkg::RatioW-2:0], 1'b0};
      quot_nxt = {quot_r[dcsm_pkg::RatioW-2:0], qbit};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == dcsm_pkg::StepW'(dcsm_pkg::RatioW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    low_r  <= low_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

/* hw/rtl/duty_cycle_sensor_mux_sequencer.sv */
// Top level: tick sequencer with multiplier step, shared serial divider and routing.
// Sequencing: a settle tick goes straight to APPLY, where its result is registered once
//   the output is free; a measure tick passes MUL, START, DIV (one bit per cycle), APPLY.
// Throughput: one transaction at a time; in_chan.ready is high only while idle.
// A finished result waits in the output register; the next tick may be taken meanwhile.
// Reset (rst_n, synchronous, active low): mode 0, next tick measures, mux not started,
//   all stores zero, select level high, no result pending.
module duty_cycle_sensor_mux_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  dcsm_in_if.sink            in_chan,
  dcsm_out_if.source         out_chan
);

  dcsm_pkg::state_t state_r, state_nxt;

  // configuration
  dcsm_pkg::mode_t  mode_r;

  // persistent sensor state
  logic                          settle_r;
  dcsm_pkg::src_t                src_r;
  logic [dcsm_pkg::WordW-1:0]    last_word_r;
  logic [dcsm_pkg::RatioW-1:0]   hist_r;
  logic [dcsm_pkg::RatioW-1:0]   volt_r;
  logic [dcsm_pkg::RatioW-1:0]   curr_r;
  logic [dcsm_pkg::RatioW-1:0]   temp_r;
  logic [dcsm_pkg::RatioW-1:0]   taux_r;
  logic                          sel_r;

  // per-transaction working registers
  logic [dcsm_pkg::CountBits-1:0] lo_r;
  logic [dcsm_pkg::CountBits-1:0] hi_r;
  logic [dcsm_pkg::WordW-1:0]     now_r;
  logic [dcsm_pkg::NumW-1:0]      prod_r;
  logic [dcsm_pkg::DenW-1:0]      sum_r;

  // output register
  logic                          ovalid_r;
  logic                          o_long_r;
  logic                          o_wv_r;
  logic [dcsm_pkg::WordW-1:0]    o_word_r;

  // next values computed in the apply step
  dcsm_pkg::src_t                src_nxt;
  logic [dcsm_pkg::WordW-1:0]    last_word_nxt;
  logic [dcsm_pkg::RatioW-1:0]   hist_nxt;
  logic [dcsm_pkg::RatioW-1:0]   volt_nxt;
  logic [dcsm_pkg::RatioW-1:0]   curr_nxt;
  logic [dcsm_pkg::RatioW-1:0]   temp_nxt;
  logic [dcsm_pkg::RatioW-1:0]   taux_nxt;
  logic                          sel_nxt;
  logic                          wv_nxt;
  logic [dcsm_pkg::WordW-1:0]    word_nxt;
  logic [dcsm_pkg::WordW-1:0]    mux_word;

  logic                          div_start;
  logic                          div_done;
  logic [dcsm_pkg::RatioW-1:0]   div_quot;
  logic [dcsm_pkg::RatioW-1:0]   ratio;
  logic [dcsm_pkg::RatioW+1:0]   hist_x3;
  logic [dcsm_pkg::RatioW-1:0]   avg;
  logic                          in_acc;
  logic                          out_free;
  logic                          apply_go;

  assign in_chan.ready = (state_r == dcsm_pkg::ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_free      = !ovalid_r || out_chan.ready;
  assign apply_go      = (state_r == dcsm_pkg::ST_APPLY) && out_free;
  assign div_start     = (state_r == dcsm_pkg::ST_START);

  dcsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (sum_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // zero pulse total gives a zero ratio
  assign ratio   = (sum_r == '0) ? '0 : div_quot;

  // quarter-weight moving average, each term truncated
  assign hist_x3 = {2'b00, hist_r} + {1'b0, hist_r, 1'b0};
  assign avg     = (hist_r == '0) ? ratio
                 : dcsm_pkg::RatioW'({2'b00, ratio[dcsm_pkg::RatioW-1:2]} +
                                     hist_x3[dcsm_pkg::RatioW+1:2]);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dcsm_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = settle_r ? dcsm_pkg::ST_APPLY : dcsm_pkg::ST_MUL;
        end
      end
      dcsm_pkg::ST_MUL: begin
        state_nxt = dcsm_pkg::ST_START;
      end
      dcsm_pkg::ST_START: begin
        state_nxt = dcsm_pkg::ST_DIV;
      end
      dcsm_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = dcsm_pkg::ST_APPLY;
        end
      end
      dcsm_pkg::ST_APPLY: begin
        if (out_free) begin
          state_nxt = dcsm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dcsm_pkg::ST_IDLE;
      end
    endcase
  end

  // routing of the ratio by mode; only takes effect on a measure tick
  always_comb begin
    src_nxt       = src_r;
    last_word_nxt = last_word_r;
    hist_nxt      = hist_r;
    volt_nxt      = volt_r;
    curr_nxt      = curr_r;
    temp_nxt      = temp_r;
    taux_nxt      = taux_r;
    sel_nxt       = sel_r;
    wv_nxt        = 1'b0;
    word_nxt      = '0;
    mux_word      = now_r & ~dcsm_pkg::MuxMask;
    unique case (mode_r)
      dcsm_pkg::MODE_REG_MUX: begin
        wv_nxt = 1'b1;
        if ((now_r != last_word_r) && (last_word_r != '0)) begin
          // switch part lost its setting: restore mux bits, drop this sample
          last_word_nxt = (now_r & dcsm_pkg::KeepMask) | (last_word_r & dcsm_pkg::MuxMask);
        end else begin
          case (src_r)
            dcsm_pkg::SRC_VOLT: begin
              volt_nxt = ratio;
              src_nxt  = dcsm_pkg::SRC_CURR;
              mux_word = mux_word | dcsm_pkg::SelVoltNext;
            end
            dcsm_pkg::SRC_CURR: begin
              curr_nxt = ratio;
              src_nxt  = dcsm_pkg::SRC_TEMP;
              mux_word = mux_word | dcsm_pkg::SelCurrNext;
            end
            dcsm_pkg::SRC_TEMP: begin
              hist_nxt = avg;
              temp_nxt = avg;
              src_nxt  = dcsm_pkg::SRC_VOLT;
              mux_word = mux_word | dcsm_pkg::SelStart;
            end
            default: begin
              src_nxt  = dcsm_pkg::SRC_VOLT;
              mux_word = mux_word | dcsm_pkg::SelStart;
            end
          endcase
          last_word_nxt = mux_word;
        end
        word_nxt = last_word_nxt;
      end
      dcsm_pkg::MODE_GPIO, dcsm_pkg::MODE_BOARD: begin
        if (sel_r) begin
          volt_nxt = ratio;
        end else begin
          taux_nxt = ratio;
        end
        sel_nxt = !sel_r;
      end
      dcsm_pkg::MODE_FIXED: begin
        volt_nxt = ratio;
      end
      default: begin
        volt_nxt = volt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dcsm_pkg::ST_IDLE;
      mode_r      <= dcsm_pkg::MODE_REG_MUX;
      settle_r    <= 1'b0;
      src_r       <= dcsm_pkg::SRC_IDLE;
      last_word_r <= '0;
      hist_r      <= '0;
      volt_r      <= '0;
      curr_r      <= '0;
      temp_r      <= '0;
      taux_r      <= '0;
      sel_r       <= 1'b1;
      ovalid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        mode_r <= dcsm_pkg::mode_t'(cfg_wdata);
      end
      // a new result may load in the same cycle the old one is taken
      if (apply_go) begin
        ovalid_r <= 1'b1;
      end else if (out_chan.ready) begin
        ovalid_r <= 1'b0;
      end
      if (apply_go) begin
        settle_r <= !settle_r;
        if (!settle_r) begin
          src_r       <= src_nxt;
          last_word_r <= last_word_nxt;
          hist_r      <= hist_nxt;
          volt_r      <= volt_nxt;
          curr_r      <= curr_nxt;
          temp_r      <= temp_nxt;
          taux_r      <= taux_nxt;
          sel_r       <= sel_nxt;
        end
      end
    end
  end

  // transaction payload and output payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      lo_r  <= in_chan.low_count;
      hi_r  <= in_chan.high_count;
      now_r <= in_chan.switch_reg_now;
    end
    if (state_r == dcsm_pkg::ST_MUL) begin
      prod_r <= dcsm_pkg::NumW'(dcsm_pkg::RatioScale) * dcsm_pkg::NumW'(lo_r);
      sum_r  <= {1'b0, lo_r} + {1'b0, hi_r};
    end
    if (apply_go) begin
      o_long_r <= settle_r;
      o_wv_r   <= !settle_r && wv_nxt;
      o_word_r <= settle_r ? '0 : word_nxt;
    end
  end

  assign out_chan.valid           = ovalid_r;
  assign out_chan.long_interval   = o_long_r;
  assign out_chan.reg_write_valid = o_wv_r;
  assign out_chan.reg_write_word  = o_word_r;
  // store values only change at the load of the output register, and the next
  // load waits until this result is taken, so they read straight from state
  assign out_chan.switch_level    = sel_r;
  assign out_chan.voltage_primary = volt_r;
  assign out_chan.current_reading = curr_r;
  assign out_chan.temp_filtered   = temp_r;
  assign out_chan.temp_aux        = taux_r;

endmodule

/* test/tb_duty_cycle_sensor_mux_sequencer.sv */
// Self-checking testbench for the duty-cycle sensor mux sequencer: predictor, scoreboard, stimulus.
`timescale 1ns / 1ps

import dcsm_pkg::*;

typedef struct packed {
  logic               long_interval;
  logic               reg_write_valid;
  logic [WordW-1:0]   reg_write_word;
  logic               switch_level;
  logic [RatioW-1:0]  voltage_primary;
  logic [RatioW-1:0]  current_reading;
  logic [RatioW-1:0]  temp_filtered;
  logic [RatioW-1:0]  temp_aux;
} tick_result_t;

// Tracks the sequencer state and holds the results that accepted ticks must produce.
class dcsm_scoreboard;
  mode_t             mode;
  logic              settle;
  src_t              src;
  logic [WordW-1:0]  reg_word;
  logic [RatioW-1:0] temp_hist;
  logic [RatioW-1:0] volt;
  logic [RatioW-1:0] curr;
  logic [RatioW-1:0] temp;
  logic [RatioW-1:0] taux;
  logic              sel;
  tick_result_t      expected_q[$];
  int                errors;
  int                ticks;
  int                measures;
  int                reg_writes;
  int                rewrites;
  int                averaged;

  function new();
    mode      = MODE_REG_MUX;
    settle    = 1'b0;
    src       = SRC_IDLE;
    reg_word  = '0;
    temp_hist = '0;
    volt      = '0;
    curr      = '0;
    temp      = '0;
    taux      = '0;
    sel       = 1'b1;
  endfunction

  function void set_mode(mode_t m);
    mode = m;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function logic [RatioW-1:0] duty_ratio(logic [CountBits-1:0] lo, logic [CountBits-1:0] hi);
    logic [63:0] sum;
    logic [63:0] prod;
    sum = 64'(lo) + 64'(hi);
    if (sum == 0) return '0;
    prod = 64'(RatioScale) * 64'(lo);
    return RatioW'(prod / sum);
  endfunction

  // quarter weight on the new sample, each term truncated on its own
  function logic [RatioW-1:0] quarter_avg(logic [RatioW-1:0] sample, logic [RatioW-1:0] hist);
    logic [31:0] s;
    logic [31:0] h;
    s = 32'(sample);
    h = 32'(hist);
    if (h == 0) return sample;
    return RatioW'(s / 4 + (h * 3) / 4);
  endfunction

  function void note_tick(logic [CountBits-1:0] lo, logic [CountBits-1:0] hi,
                          logic [WordW-1:0] now);
    tick_result_t      r;
    logic [RatioW-1:0] ratio;
    logic [WordW-1:0]  word;
    r = '0;
    ticks++;
    if (!settle) begin
      ratio = duty_ratio(lo, hi);
      measures++;
      case (mode)
        MODE_REG_MUX: begin
          if (now != reg_word && reg_word != 0) begin
            // part was reset: restore mux bits, drop the sample
            reg_word = (now & KeepMask) | (reg_word & MuxMask);
            rewrites++;
          end else begin
            word = now & ~MuxMask;
            case (src)
              SRC_VOLT: begin
                volt = ratio;
                src  = SRC_CURR;
                word |= SelVoltNext;
              end
              SRC_CURR: begin
                curr = ratio;
                src  = SRC_TEMP;
                word |= SelCurrNext;
              end
              SRC_TEMP: begin
                if (temp_hist != 0) averaged++;
                temp_hist = quarter_avg(ratio, temp_hist);
                temp      = temp_hist;
                src       = SRC_VOLT;
                word |= SelStart;
              end
              default: begin
                src = SRC_VOLT;
                word |= SelStart;
              end
            endcase
            reg_word = word;
          end
          r.reg_write_valid = 1'b1;
          r.reg_write_word  = reg_word;
          reg_writes++;
        end
        MODE_GPIO, MODE_BOARD: begin
          if (sel) volt = ratio;
          else taux = ratio;
          sel = ~sel;
        end
        default: volt = ratio;
      endcase
    end else begin
      r.long_interval = 1'b1;
    end
    settle = ~settle;
    r.switch_level    = sel;
    r.voltage_primary = volt;
    r.current_reading = curr;
    r.temp_filtered   = temp;
    r.temp_aux        = taux;
    expected_q.push_back(r);
  endfunction

  function void check_field(string name, logic [WordW-1:0] want, logic [WordW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(tick_result_t got);
    tick_result_t want;
    if (expected_q.size() == 0) begin
      $error("result transaction with no tick outstanding");
      errors++;
      return;
    end
    want = expected_q.pop_front();
    check_field("long_interval", 32'(want.long_interval), 32'(got.long_interval));
    check_field("reg_write_valid", 32'(want.reg_write_valid), 32'(got.reg_write_valid));
    check_field("reg_write_word", want.reg_write_word, got.reg_write_word);
    check_field("switch_level", 32'(want.switch_level), 32'(got.switch_level));
    check_field("voltage_primary", 32'(want.voltage_primary), 32'(got.voltage_primary));
    check_field("current_reading", 32'(want.current_reading), 32'(got.current_reading));
    check_field("temp_filtered", 32'(want.temp_filtered), 32'(got.temp_filtered));
    check_field("temp_aux", 32'(want.temp_aux), 32'(got.temp_aux));
  endfunction
endclass

module tb_duty_cycle_sensor_mux_sequencer;

  // no-acceptance cycles tolerated; HoldCycles below sets the long receiver hold
  localparam int StallLimit = 3000;
  localparam int HoldCycles = 400;
  localparam int PhaseTicks = 75;
  localparam logic [CountBits-1:0] CountMax = '1;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_wdata;

  dcsm_in_if  in_ch ();
  dcsm_out_if out_ch ();

  dcsm_scoreboard sb;

  bit tx_idle_on;      // sender inserts random gaps
  bit rx_idle_on;      // receiver drops ready in random bursts
  bit long_hold_req;   // receiver holds off for HoldCycles
  int mode_writes;
  int idle_cycles;

  duty_cycle_sensor_mux_sequencer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Sender side. Every task starts its work at a falling edge; send_tick returns
  // at the rising edge where the tick was taken, so valid is either replaced by
  // the next tick or dropped at the following falling edge, never both.
  // ---------------------------------------------------------------------------
  task automatic send_tick(logic [CountBits-1:0] lo, logic [CountBits-1:0] hi,
                           logic [WordW-1:0] now);
    @(negedge clk);
    in_ch.low_count      = lo;
    in_ch.high_count     = hi;
    in_ch.switch_reg_now = now;
    in_ch.valid          = 1'b1;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.note_tick(lo, hi, now);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // sender holds off until every outstanding result has come back
  task automatic drain();
    drop_valid();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mode register is only touched while the block is idle
  task automatic write_mode(mode_t m);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = m;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_mode(m);
    mode_writes++;
  endtask

  task automatic sender_gap();
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      drop_valid();
      repeat ($urandom_range(1, 19) - 1) @(negedge clk);
    end
  endtask

  // Mode 0 only advances the mux when the switch word read back matches the one
  // last written (or none is written yet), so most measure ticks follow that word;
  // the rest either flip one bit or bring a fresh word, which looks like a part reset.
  task automatic send_random_tick();
    logic [CountBits-1:0] lo;
    logic [CountBits-1:0] hi;
    logic [WordW-1:0]     now;
    case ($urandom_range(0, 9))
      0: begin
        lo = '0;
        hi = '0;
      end
      1: begin
        lo = $urandom_range(0, 1) ? CountMax : CountBits'($urandom_range(0, 3));
        hi = $urandom_range(0, 1) ? CountMax : CountBits'($urandom_range(0, 3));
      end
      2, 3, 4: begin
        lo = CountBits'($urandom_range(0, 255));
        hi = CountBits'($urandom_range(0, 255));
      end
      default: begin
        lo = CountBits'($urandom);
        hi = CountBits'($urandom);
      end
    endcase
    now = $urandom;
    if (sb.mode == MODE_REG_MUX && !sb.settle) begin
      case ($urandom_range(0, 19))
        0:       now = sb.reg_word ^ (32'h1 << $urandom_range(0, 31));
        1:       now = $urandom;
        default: now = sb.reg_word;
      endcase
    end
    send_tick(lo, hi, now);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random ready bursts, plus one long hold on request so the
  // output register fills and the input channel backs up.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int burst;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        burst = $urandom_range(1, 19);
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // every accepted result transaction is checked against the oldest expectation
  always @(posedge clk) begin
    tick_result_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.long_interval   = out_ch.long_interval;
      got.reg_write_valid = out_ch.reg_write_valid;
      got.reg_write_word  = out_ch.reg_write_word;
      got.switch_level    = out_ch.switch_level;
      got.voltage_primary = out_ch.voltage_primary;
      got.current_reading = out_ch.current_reading;
      got.temp_filtered   = out_ch.temp_filtered;
      got.temp_aux        = out_ch.temp_aux;
      sb.check_result(got);
    end
  end

  // watchdog: ends the run if neither channel moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("timeout: no transaction for %0d cycles", idle_cycles);
      $display("duty_cycle_sensor_mux_sequencer: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    mode_t plan [12];
    logic [WordW-1:0] w;
    plan = '{MODE_REG_MUX, MODE_GPIO, MODE_BOARD, MODE_FIXED, MODE_REG_MUX, MODE_FIXED,
             MODE_BOARD, MODE_REG_MUX, MODE_GPIO, MODE_REG_MUX, MODE_BOARD, MODE_REG_MUX};
    sb                   = new();
    idle_cycles          = 0;
    mode_writes          = 0;
    tx_idle_on           = 1'b0;
    rx_idle_on           = 1'b0;
    long_hold_req        = 1'b0;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = MODE_REG_MUX;
    in_ch.valid          = 1'b0;
    in_ch.low_count      = '0;
    in_ch.high_count     = '0;
    in_ch.switch_reg_now = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed part, mode 0 from reset: start-up word, full-scale and empty
    // counts, each mux source twice so the temperature average kicks in, then a
    // part reset (read-back differs) and recovery from it.
    send_tick('0, '0, 32'h1234_5678);           // zero sum, mux start
    send_tick(CountMax, CountMax, 32'hFFFF_FFFF);
    send_tick(CountMax, '0, sb.reg_word);      // voltage at full scale
    send_tick('0, '0, 32'h0000_0000);
    send_tick('0, CountMax, sb.reg_word);      // current at zero
    send_tick('0, '0, 32'hFFFF_FFFF);
    send_tick(CountMax, CountMax, sb.reg_word); // temperature, empty history
    send_tick('0, '0, '0);
    send_tick(CountMax, 24'd1, sb.reg_word);
    send_tick(24'd1, '0, '0);
    send_tick(24'd1, CountMax, sb.reg_word);
    send_tick('0, '0, '0);
    send_tick(24'd3, 24'd1, sb.reg_word);       // temperature averaged
    send_tick('0, '0, '0);
    w = ~sb.reg_word;
    send_tick(24'd5, 24'd5, w);                 // part reset detected
    send_tick('0, '0, '0);
    send_tick(24'd7, 24'd9, sb.reg_word);
    send_tick('0, '0, '0);
    // switched-source modes share the select level; fixed source last
    write_mode(MODE_GPIO);
    send_tick(CountMax, '0, '0);
    send_tick('0, '0, '0);
    send_tick('0, CountMax, 32'hFFFF_FFFF);
    write_mode(MODE_BOARD);
    send_tick('0, '0, '0);
    send_tick(24'd2, 24'd6, '0);
    write_mode(MODE_FIXED);
    send_tick('0, '0, '0);
    send_tick(CountMax, 24'd1, '0);

    // Random phases: each starts with a mode write, and modes change with the
    // sequencer mid-cycle. Every third phase runs without gaps; the last runs
    // with no idling on either side.
    foreach (plan[p]) begin
      write_mode(plan[p]);
      tx_idle_on = (p % 3 != 2) && (p != 11);
      rx_idle_on = (p % 4 != 3) && (p != 11);
      for (int i = 0; i < PhaseTicks; i++) begin
        if (p == 4 && i == PhaseTicks / 2) drain();
        if (p == 6 && i == 20) begin
          // back-pressure: receiver stalls while ticks keep coming
          long_hold_req = 1'b1;
          repeat (10) send_random_tick();
        end
        send_random_tick();
        sender_gap();
      end
    end

    drop_valid();
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("covered %0d ticks, %0d measures, %0d register writes, %0d part-reset rewrites",
             sb.ticks, sb.measures, sb.reg_writes, sb.rewrites);
    $display("%0d averaged temperature updates, %0d mode writes, %0d failures",
             sb.averaged, mode_writes, sb.errors);
    if (sb.errors == 0) begin
      $display("duty_cycle_sensor_mux_sequencer: match");
    end else begin
      $display("duty_cycle_sensor_mux_sequencer: mismatch");
    end
    $finish;
  end

endmodule

/* duty_cycle_sensor_mux_sequencer.f */
hw/rtl/dcsm_pkg.sv
hw/rtl/dcsm_if.sv
hw/rtl/dcsm_div.sv
hw/rtl/duty_cycle_sensor_mux_sequencer.sv
test/tb_duty_cycle_sensor_mux_sequencer.sv
